>>> rtl/sms_pkg.sv
// Shared types and constants for the sorted matrix staircase search block.
// No dependencies; every other file of the block imports this package.
package sms_pkg;

    // Field widths fixed by the item format
    localparam int VALUE_W   = 32;
    localparam int ROW_IDX_W = 4;
    localparam int COL_IDX_W = 4;
    localparam int CNT_W     = 5;

    // Default store size
    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = CNT_W;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

    // Item modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic write_en;    // store the accepted element
        logic start;       // load walk origin, read top-right element
        logic step;        // move one place, read next element
        logic found_load;  // capture the walk outcome
        logic found_val;
        logic emit;        // move the outcome into the result register
    } sms_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;       // no rows or no columns in use
        logic hit;         // current element equals the target
        logic step_off;    // the next move leaves the area in use
        logic out_free;    // result register can take a new item
    } sms_status_t;

endpackage

>>> rtl/sms_req_if.sv
// Request channel of the staircase search block: valid/ready plus item fields.
// Depends on sms_pkg.
interface sms_req_if
    import sms_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [ROW_IDX_W-1:0]      row_index;
    logic [COL_IDX_W-1:0]      col_index;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, mode, row_index, col_index, value, input ready);
    modport sink   (input valid, mode, row_index, col_index, value, output ready);
endinterface

>>> rtl/sms_rsp_if.sv
// Result channel of the staircase search block: valid/ready plus found flag.
// Depends on sms_pkg only by convention; carries no package types.
interface sms_rsp_if
    import sms_pkg::*;
();
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, found, input ready);
    modport sink   (input valid, found, output ready);
endinterface

>>> rtl/sms_datapath.sv
// Datapath: matrix store, configuration registers, walk position, compare
// and the result register. Depends on sms_pkg.
module sms_datapath
    import sms_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic [ROW_IDX_W-1:0]      row_index,
    input  logic [COL_IDX_W-1:0]      col_index,
    input  logic signed [VALUE_W-1:0] value,
    input  sms_cmd_t                  cmd,
    output sms_status_t               status,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic                      rsp_found
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);

    logic signed [VALUE_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]          rows_in_use_reg;
    logic [CNT_W-1:0]          cols_in_use_reg;
    logic [RCW-1:0]            rows_eff;
    logic [CCW-1:0]            cols_eff;
    logic [RCW-1:0]            rows_lim_reg;
    logic [RCW-1:0]            r_reg;
    logic [RCW-1:0]            r_next;
    logic [CCW-1:0]            c_reg;     // column plus one
    logic [CCW-1:0]            c_next;
    logic signed [VALUE_W-1:0] target_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             wr_addr;
    logic                      wr_in_range;
    logic                      greater;
    logic                      found_reg;
    logic                      out_valid_reg;
    logic                      out_found_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= '0;
            cols_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS_IN_USE: rows_in_use_reg <= cfg_data;
                REG_COLS_IN_USE: cols_in_use_reg <= cfg_data;
            endcase
        end
    end

    // Saturate counts at the store size
    assign rows_eff = (32'(rows_in_use_reg) > MAX_ROWS) ? RCW'(MAX_ROWS)
                                                         : RCW'(rows_in_use_reg);
    assign cols_eff = (32'(cols_in_use_reg) > MAX_COLS) ? CCW'(MAX_COLS)
                                                         : CCW'(cols_in_use_reg);

    assign greater = rd_data_reg > target_reg;

    // Next walk position
    always_comb
    begin
        r_next = r_reg;
        c_next = c_reg;
        if (cmd.start)
        begin
            r_next = '0;
            c_next = cols_eff;
        end
        else if (cmd.step)
        begin
            if (greater)
                c_next = c_reg - CCW'(1);
            else
                r_next = r_reg + RCW'(1);
        end
    end

    assign rd_addr = AW'(32'(r_next) * MAX_COLS + 32'(c_next) - 32'd1);
    assign wr_addr = AW'(32'(row_index) * MAX_COLS + 32'(col_index));
    assign wr_in_range = (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);

    // Matrix store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.write_en && wr_in_range)
            mem[wr_addr] <= value;
        if (cmd.start || cmd.step)
            rd_data_reg <= mem[rd_addr];
    end

    // Walk registers
    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        c_reg <= c_next;
        if (cmd.start)
        begin
            target_reg   <= value;
            rows_lim_reg <= rows_eff;
        end
        if (cmd.found_load)
            found_reg <= cmd.found_val;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_found_reg <= found_reg;
    end

    assign status.empty    = (rows_eff == '0) || (cols_eff == '0);
    assign status.hit      = rd_data_reg == target_reg;
    assign status.step_off = greater ? (c_reg == CCW'(1))
                                     : ((r_reg + RCW'(1)) == rows_lim_reg);
    assign status.out_free = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp_found = out_found_reg;

endmodule

>>> rtl/sms_ctrl.sv
// Controller: sequences writes, the staircase walk and the result hand-off.
// Depends on sms_pkg.
module sms_ctrl
    import sms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_mode,
    output logic        req_ready,
    input  sms_status_t status,
    output sms_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_mode == MODE_WRITE)
                        cmd.write_en = 1'b1;
                    else if (status.empty)
                    begin
                        cmd.found_load = 1'b1;
                        cmd.found_val  = 1'b0;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (status.hit)
                begin
                    cmd.found_load = 1'b1;
                    cmd.found_val  = 1'b1;
                    state_next     = ST_FINISH;
                end
                else if (status.step_off)
                begin
                    cmd.found_load = 1'b1;
                    cmd.found_val  = 1'b0;
                    state_next     = ST_FINISH;
                end
                else
                    cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/sorted_matrix_staircase_search.sv
// Top level of the sorted matrix staircase search block.
// Depends on sms_pkg, sms_req_if, sms_rsp_if, sms_ctrl and sms_datapath.
//
// Usage:
//   req carries items. mode = write stores value at (row_index, col_index);
//   writes outside the store are dropped, and a write gives no result.
//   mode = search walks the area in use from its top-right element for value
//   and returns one item on rsp with found.
//   cfg_we/cfg_index/cfg_data set rows_in_use and cols_in_use; write them
//   only while the block is idle. Counts above the store size saturate.
// Timing:
//   A write is taken while idle, and writes may arrive back to back.
//   A search examines one element per cycle in the walk loop, set by the
//   registered read port of the store: at most rows + cols - 1 elements,
//   the first read included, and then the hand-off of the result. An empty
//   area goes straight to the hand-off without a walk.
//   The result item appears on rsp the cycle after the hand-off.
// Reset clears the configuration (area empty), the controller and rsp.valid;
// the store contents stay undefined until written.
// A stalled rsp holds its item; the block keeps accepting the next item and
// holds a finished search in its hand-off state until the result slot frees.
module sorted_matrix_staircase_search
    import sms_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sms_req_if.sink               req,
    sms_rsp_if.source             rsp
);

    sms_cmd_t    cmd;
    sms_status_t status;

    // Sequence the walk
    sms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Store, walk position, compare and result register
    sms_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row_index (req.row_index),
        .col_index (req.col_index),
        .value     (req.value),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_found (rsp.found)
    );

`ifndef ASSERT_OFF
    // A walk never starts on an empty area
    a_start_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !status.empty)
        else $error("walk started on empty area");

    // A finished search never overwrites a pending result
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result overwritten");

    // An accepted search closes the request side for the next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.mode == MODE_SEARCH) |=> !req.ready)
        else $error("request accepted during a search");

    // Datapath commands are mutually exclusive
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.write_en, cmd.start, cmd.step, cmd.emit}))
        else $error("conflicting datapath commands");
`endif

endmodule
